/* src/assert_macros.svh */
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge, suspended while rst is high
`define CFUS_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clk edge, reset included
`define CFUS_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cfus_pkg.sv */
`timescale 1ns / 1ps
package cfus_pkg;

  // seconds to days: drop 7 low bits (86400 = 128 * 675), then divide by 675
  localparam int unsigned DAY_LO_BITS = 7;
  localparam logic [9:0]  DAY_LO_DIV  = 10'd675;
  localparam int unsigned DAY_MUL_K   = 34;
  localparam logic [24:0] DAY_MUL     = 25'((64'd1 << DAY_MUL_K) / 64'd675);

  // days to civil date, day count re-based to 0000-03-01
  localparam logic [23:0] EPOCH_SHIFT = 24'd719468;
  localparam logic [17:0] ERA_DAYS    = 18'd146097;
  localparam logic [17:0] ERA_LAST    = 18'd146096;
  localparam logic [15:0] ERA_YEARS   = 16'd400;
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;
  localparam logic [3:0]  MP_WRAP     = 4'd10;
  localparam logic [3:0]  FEBRUARY    = 4'd2;
  localparam logic [3:0]  MONTH_MAR   = 4'd3;
  localparam logic [3:0]  MONTH_BACK  = 4'd9;

  // reciprocal multipliers, rounded up, exact over the operand ranges used
  localparam int unsigned ERA_MUL_K  = 42;
  localparam logic [24:0] ERA_MUL    = 25'(((64'd1 << ERA_MUL_K) + 64'd146096) / 64'd146097);
  localparam int unsigned Q4_MUL_K   = 29;
  localparam logic [18:0] Q4_MUL     = 19'(((64'd1 << Q4_MUL_K) + 64'd1459) / 64'd1460);
  localparam int unsigned CEN_MUL_K  = 34;
  localparam logic [18:0] CEN_MUL    = 19'(((64'd1 << CEN_MUL_K) + 64'd36523) / 64'd36524);
  localparam int unsigned YR_MUL_K   = 27;
  localparam logic [18:0] YR_MUL     = 19'(((64'd1 << YR_MUL_K) + 64'd364) / 64'd365);
  localparam int unsigned C100_MUL_K = 16;
  localparam logic [9:0]  C100_MUL   = 10'(((64'd1 << C100_MUL_K) + 64'd99) / 64'd100);
  localparam int unsigned MP_MUL_K   = 19;
  localparam logic [11:0] MP_MUL     = 12'(((64'd1 << MP_MUL_K) + 64'd152) / 64'd153);
  localparam int unsigned HR_MUL_K   = 29;
  localparam logic [17:0] HR_MUL     = 18'(((64'd1 << HR_MUL_K) + 64'd3599) / 64'd3600);
  localparam int unsigned MIN_MUL_K  = 18;
  localparam logic [12:0] MIN_MUL    = 13'(((64'd1 << MIN_MUL_K) + 64'd59) / 64'd60);

  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  // pipeline depths
  localparam int unsigned SPLIT_STAGES = 3;
  localparam int unsigned CIV_STAGES   = 11;
  localparam int unsigned TOD_CALC     = 5;
  localparam int unsigned TOD_DELAY    = CIV_STAGES - TOD_CALC;
  localparam int unsigned TOTAL_LAT    = SPLIT_STAGES + CIV_STAGES;

  typedef struct packed {
    logic        valid;
    logic [23:0] days;
    logic [16:0] tod;
  } split_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // day of a march-based year on which month slot mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/cfus_split.sv */
`timescale 1ns / 1ps
module cfus_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [39:0]         secs,
  output cfus_pkg::split_t    dout
);
  import cfus_pkg::*;

  logic        v1;
  logic [32:0] sx1;
  logic [6:0]  lo1;
  logic [57:0] p1;

  logic        v2;
  logic [32:0] sx2;
  logic [6:0]  lo2;
  logic [23:0] qe2;
  logic [32:0] pq2;

  logic [23:0] qe2_next;
  logic [10:0] r3;
  logic        ge3;
  logic [10:0] hi3;

  assign qe2_next = p1[57:34];

  // estimate is the true quotient or one below it
  always_comb begin
    r3  = 11'(sx2 - pq2);
    ge3 = (r3 >= 11'(DAY_LO_DIV));
    hi3 = ge3 ? (r3 - 11'(DAY_LO_DIV)) : r3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      v1         <= load;
      v2         <= v1;
      dout.valid <= v2;
    end
    sx1       <= secs[39:DAY_LO_BITS];
    lo1       <= secs[DAY_LO_BITS-1:0];
    p1        <= 58'(secs[39:DAY_LO_BITS]) * 58'(DAY_MUL);
    sx2       <= sx1;
    lo2       <= lo1;
    qe2       <= qe2_next;
    pq2       <= 33'(qe2_next) * 33'(DAY_LO_DIV);
    dout.days <= qe2 + 24'(ge3);
    dout.tod  <= {hi3[9:0], lo2};
  end

endmodule

/* src/cfus_tod.sv */
`timescale 1ns / 1ps
module cfus_tod (
  input  logic                clk,
  input  logic [16:0]         tod,
  output cfus_pkg::tod_t      dout
);
  import cfus_pkg::*;

  logic [16:0] tod1;
  logic [34:0] ph1;
  logic [16:0] tod2;
  logic [4:0]  hr2;
  logic [16:0] hp2;
  logic [4:0]  hr3;
  logic [11:0] rem3;
  logic [4:0]  hr4;
  logic [11:0] rem4;
  logic [24:0] pm4;
  logic [4:0]  hr5;
  logic [11:0] rem5;
  logic [5:0]  mn5;
  logic [11:0] sp5;

  logic [4:0]  hr2_next;
  logic [5:0]  mn5_next;
  tod_t        calc;
  tod_t        dly [TOD_DELAY];

  assign hr2_next = ph1[33:29];
  assign mn5_next = pm4[23:18];

  always_comb begin
    calc.hour   = hr5;
    calc.minute = mn5;
    calc.second = 6'(rem5 - sp5);
  end

  always_ff @(posedge clk) begin
    tod1  <= tod;
    ph1   <= 35'(tod) * 35'(HR_MUL);
    tod2  <= tod1;
    hr2   <= hr2_next;
    hp2   <= 17'(hr2_next) * 17'(SEC_PER_HOUR);
    hr3   <= hr2;
    rem3  <= 12'(tod2 - hp2);
    hr4   <= hr3;
    rem4  <= rem3;
    pm4   <= 25'(rem3) * 25'(MIN_MUL);
    hr5   <= hr4;
    rem5  <= rem4;
    mn5   <= mn5_next;
    sp5   <= 12'(mn5_next) * 12'(SEC_PER_MIN);
    // delay line lines up with the date path
    dly[0] <= calc;
    for (int i = 1; i < TOD_DELAY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign dout = dly[TOD_DELAY-1];

endmodule

/* src/cfus_civil.sv */
`timescale 1ns / 1ps
module cfus_civil (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  logic [23:0]         days,
  output cfus_pkg::date_t     dout
);
  import cfus_pkg::*;

  logic [CIV_STAGES-1:0] vld;

  logic [23:0] z1, z2, z3;
  logic [48:0] pe2;
  logic [23:0] eb3;
  logic [15:0] yb3, yb4, yb5, yb6, yb7, yb8, yb9, yb10;
  logic [17:0] doe4, doe5, doe6, doe7, doe8;
  logic [36:0] pa5, pb5;
  logic        last5;
  logic [17:0] t6;
  logic [36:0] py7;
  logic [8:0]  yoe8, yoe9, yoe10;
  logic [17:0] p365_8;
  logic [18:0] pc8;
  logic [8:0]  doy9, doy10;
  logic [22:0] pmp10;

  logic [6:0]  era3_next;
  logic [8:0]  yoe8_next;
  logic [10:0] v10_next;
  logic [3:0]  mp11;
  logic [3:0]  mon11;

  assign era3_next = pe2[48:42];
  assign yoe8_next = py7[35:27];
  assign v10_next  = {doy9, 2'b00} + 11'(doy9) + 11'd2;
  assign mp11      = pmp10[22:19];
  assign mon11     = (mp11 < MP_WRAP) ? (mp11 + MONTH_MAR) : (mp11 - MONTH_BACK);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[CIV_STAGES-2:0], valid};
    end
    z1     <= days + EPOCH_SHIFT;
    z2     <= z1;
    pe2    <= 49'(z1) * 49'(ERA_MUL);
    z3     <= z2;
    eb3    <= 24'(era3_next) * 24'(ERA_DAYS);
    yb3    <= 16'(era3_next) * ERA_YEARS;
    doe4   <= 18'(z3 - eb3);
    yb4    <= yb3;
    pa5    <= 37'(doe4) * 37'(Q4_MUL);
    pb5    <= 37'(doe4) * 37'(CEN_MUL);
    last5  <= (doe4 == ERA_LAST);
    doe5   <= doe4;
    yb5    <= yb4;
    // fold out the missing leap days to get a uniform 365-day year count
    t6     <= doe5 - 18'(pa5[36:29]) + 18'(pb5[36:34]) - 18'(last5);
    doe6   <= doe5;
    yb6    <= yb5;
    py7    <= 37'(t6) * 37'(YR_MUL);
    doe7   <= doe6;
    yb7    <= yb6;
    yoe8   <= yoe8_next;
    p365_8 <= 18'(yoe8_next) * 18'(YEAR_DAYS);
    pc8    <= 19'(yoe8_next) * 19'(C100_MUL);
    doe8   <= doe7;
    yb8    <= yb7;
    doy9   <= 9'(doe8 - (p365_8 + 18'(yoe8[8:2]) - 18'(pc8[18:16])));
    yoe9   <= yoe8;
    yb9    <= yb8;
    pmp10  <= 23'(v10_next) * 23'(MP_MUL);
    doy10  <= doy9;
    yoe10  <= yoe9;
    yb10   <= yb9;
    dout.year  <= 16'(yoe10) + yb10 + 16'(mon11 <= FEBRUARY);
    dout.month <= mon11;
    dout.day   <= 5'(doy10 - month_start(mp11) + 9'd1);
  end

  assign dout.valid = vld[CIV_STAGES-1];

endmodule

/* src/calendar_from_unix_seconds.sv */
`timescale 1ns / 1ps
// unix seconds to gregorian date and time of day, fully pipelined
// a start passes the split stages and then the civil date stages before its done strobe
// throughput: one transaction per cycle, busy is low whenever rst is low
// the 14 stages are set by reciprocal multiplies, each followed by a register
// reset clears every valid bit; no done appears for items in flight at reset
module calendar_from_unix_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [39:0] unix_seconds,
  output logic        done,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);
  import cfus_pkg::*;

  logic   load;
  split_t split;
  date_t  date;
  tod_t   tday;

  assign busy = rst;
  assign load = start && !busy;

  cfus_split u_split (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .secs (unix_seconds),
    .dout (split)
  );

  cfus_civil u_civil (
    .clk   (clk),
    .rst   (rst),
    .valid (split.valid),
    .days  (split.days),
    .dout  (date)
  );

  cfus_tod u_tod (
    .clk  (clk),
    .tod  (split.tod),
    .dout (tday)
  );

  assign done         = date.valid;
  assign year         = date.year;
  assign month        = date.month;
  assign day_of_month = date.day;
  assign hour         = tday.hour;
  assign minute       = tday.minute;
  assign second       = tday.second;

endmodule

/* src/cfus_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfus_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);
  import cfus_pkg::*;

  `CFUS_CHK(a_done_follows, start && !busy |-> ##TOTAL_LAT done, "transaction lost")
  `CFUS_CHK(a_done_has_src, done |-> $past(start && !busy, TOTAL_LAT), "spurious done")
  `CFUS_CHK(a_fields_sane, done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59), "field out of range")
  `CFUS_CHK_ALWAYS(a_rst_quiet, rst |=> !done, "done right after reset")

endmodule

bind calendar_from_unix_seconds cfus_checker u_chk (.*);
